// ----- hdl/region_grow_mask_tracker_top_defines.svh -----
// Assertion helpers shared by the tracker modules.
// Both expect signals named clock and reset in the enclosing module.
`ifndef REGION_GROW_MASK_TRACKER_TOP_DEFINES_SVH
`define REGION_GROW_MASK_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication.
`define RGMT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RGMT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/rgmt_pkg.sv -----
package rgmt_pkg;

   localparam int X_W = 10;
   localparam int Y_W = 9;

   typedef enum logic [2:0] {
      MODE_CLEAR  = 3'd0,
      MODE_LOAD   = 3'd1,
      MODE_START  = 3'd2,
      MODE_SEED   = 3'd3,
      MODE_CHECK  = 3'd4,
      MODE_ACCEPT = 3'd5,
      MODE_REJECT = 3'd6,
      MODE_CLOSE  = 3'd7
   } mode_type;

   localparam logic [1:0] DIR_EAST  = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_WEST  = 2'd2;
   localparam logic [1:0] DIR_NORTH = 2'd3;

   localparam logic [1:0] ST_FREE     = 2'd0;
   localparam logic [1:0] ST_FORBID   = 2'd1;
   localparam logic [1:0] ST_EXPLORED = 2'd2;
   localparam logic [1:0] ST_ACK      = 2'd3;

   localparam logic [1:0] REGION_NONE   = 2'd0;
   localparam logic [1:0] REGION_BODY   = 2'd1;
   localparam logic [1:0] REGION_BORDER = 2'd2;

   typedef struct packed {
      logic [2:0]     mode;
      logic [X_W-1:0] pos_x;
      logic [Y_W-1:0] pos_y;
      logic [1:0]     direction;
      logic           forbid_bit;
   } req_type;

   typedef struct packed {
      logic [1:0]     status;
      logic [X_W-1:0] nb_x;
      logic [Y_W-1:0] nb_y;
      logic [X_W-1:0] win_x;
      logic [Y_W-1:0] win_y;
      logic [X_W-1:0] win_w;
      logic [Y_W-1:0] win_h;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic read;
      logic walk;
      logic sweep;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       win_empty;
      logic       walk_last;
      logic       sweep_last;
      logic       slot_free;
   } sts_type;

endpackage

// ----- hdl/rgmt_ctrl.sv -----
`include "region_grow_mask_tracker_top_defines.svh"

module rgmt_ctrl
   import rgmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output logic    req_stall,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CALC,
      S_READ,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_INIT: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            if (sts.mode == MODE_CHECK) begin
               state_in = S_READ;
            end else if (sts.mode == MODE_CLEAR && !sts.win_empty) begin
               state_in = S_WALK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_DONE;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   `RGMT_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0({cmd.capture, cmd.calc, cmd.read, cmd.walk, cmd.sweep, cmd.commit}), "more than one datapath command")
   `RGMT_ASSERT_NEXT(a_hold_done, state_ff == S_DONE && !sts.slot_free, state_ff == S_DONE, "result dropped while output slot busy")
   `RGMT_ASSERT_NEXT(a_capture_calc, cmd.capture, cmd.calc, "captured item not processed next cycle")

endmodule

// ----- hdl/rgmt_dp.sv -----
`include "region_grow_mask_tracker_top_defines.svh"

module rgmt_dp
   import rgmt_pkg::*;
#(
   parameter int IMG_WIDTH  = 640,
   parameter int IMG_HEIGHT = 480
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   input  logic    rsp_stall,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CXW  = ($clog2(IMG_WIDTH) > X_W) ? $clog2(IMG_WIDTH) : X_W;
   localparam int CYW  = ($clog2(IMG_HEIGHT) > Y_W) ? $clog2(IMG_HEIGHT) : Y_W;
   localparam int NPIX = IMG_WIDTH * IMG_HEIGHT;
   localparam int AW   = $clog2(NPIX);

   localparam logic [CXW-1:0] X_LAST     = CXW'(IMG_WIDTH - 1);
   localparam logic [CYW-1:0] Y_LAST     = CYW'(IMG_HEIGHT - 1);
   localparam logic [AW-1:0]  A_LAST     = AW'(NPIX - 1);
   localparam logic [AW-1:0]  ROW_STRIDE = AW'(IMG_WIDTH);

   // pixel masks
   logic       expl_mem [NPIX];
   logic       forb_mem [NPIX];
   logic [1:0] reg_mem  [NPIX];

   req_type        req_ff;
   logic [AW-1:0]  idx_ff;
   logic [AW-1:0]  tgt_idx_ff;
   logic           tgt_valid_ff;
   logic [CXW-1:0] nb_x_ff;
   logic [CYW-1:0] nb_y_ff;
   logic           nb_in_ff;
   logic [CXW-1:0] cx_ff;
   logic [CYW-1:0] cy_ff;
   logic           expl_rd_ff;
   logic           forb_rd_ff;
   logic [CXW-1:0] seed_x_ff, cur_x_ff, box_xmin_ff, box_xmax_ff;
   logic [CYW-1:0] seed_y_ff, cur_y_ff, box_ymin_ff, box_ymax_ff;
   logic [CXW-1:0] win_x_ff, win_xe_ff;
   logic [CYW-1:0] win_y_ff, win_ye_ff;
   logic [CXW:0]   win_w_ff;
   logic [CYW:0]   win_h_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic [CXW-1:0] cur_x_in, win_x_in, win_xe_in;
   logic [CYW-1:0] cur_y_in, win_y_in, win_ye_in;
   logic [CXW:0]   win_w_in;
   logic [CYW:0]   win_h_in;

   logic [CXW-1:0] px_ext, sat_x, nb_x_calc, x_sel;
   logic [CYW-1:0] py_ext, sat_y, nb_y_calc, y_sel;
   logic           nb_ok, pos_in;
   logic [AW-1:0]  idx_calc, row_jump;
   logic           row_end, walk_last, chk_new, slot_free;
   logic [1:0]     status_calc;
   logic           expl_we, expl_wd, forb_we, forb_wd, reg_we;
   logic [1:0]     reg_wd;

   assign px_ext = CXW'(req_ff.pos_x);
   assign py_ext = CYW'(req_ff.pos_y);
   assign sat_x  = (px_ext > X_LAST) ? X_LAST : px_ext;
   assign sat_y  = (py_ext > Y_LAST) ? Y_LAST : py_ext;
   assign pos_in = (px_ext <= X_LAST) && (py_ext <= Y_LAST);

   // neighbor of the seed; flag it when it falls off the image
   always_comb begin
      nb_x_calc = seed_x_ff;
      nb_y_calc = seed_y_ff;
      case (req_ff.direction)
         DIR_EAST: begin
            nb_x_calc = seed_x_ff + CXW'(1);
            nb_ok     = seed_x_ff != X_LAST;
         end
         DIR_SOUTH: begin
            nb_y_calc = seed_y_ff + CYW'(1);
            nb_ok     = seed_y_ff != Y_LAST;
         end
         DIR_WEST: begin
            nb_x_calc = seed_x_ff - CXW'(1);
            nb_ok     = seed_x_ff != '0;
         end
         default: begin
            nb_y_calc = seed_y_ff - CYW'(1);
            nb_ok     = seed_y_ff != '0;
         end
      endcase
   end

   always_comb begin
      case (req_ff.mode)
         MODE_LOAD: begin
            x_sel = px_ext;
            y_sel = py_ext;
         end
         MODE_CLEAR: begin
            x_sel = win_x_ff;
            y_sel = win_y_ff;
         end
         default: begin
            x_sel = nb_x_calc;
            y_sel = nb_y_calc;
         end
      endcase
   end

   assign idx_calc = AW'(y_sel) * ROW_STRIDE + AW'(x_sel);

   assign row_end   = cx_ff == win_xe_ff;
   assign walk_last = row_end && (cy_ff == win_ye_ff);
   assign row_jump  = idx_ff + ROW_STRIDE - AW'(win_xe_ff - win_x_ff);

   assign chk_new   = (req_ff.mode == MODE_CHECK) && nb_in_ff && !expl_rd_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (req_ff.mode == MODE_CHECK) begin
         if (!nb_in_ff || expl_rd_ff) begin
            status_calc = ST_EXPLORED;
         end else if (forb_rd_ff) begin
            status_calc = ST_FORBID;
         end else begin
            status_calc = ST_FREE;
         end
      end else begin
         status_calc = ST_ACK;
      end
   end

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      win_x_in  = win_x_ff;
      win_y_in  = win_y_ff;
      win_xe_in = win_xe_ff;
      win_ye_in = win_ye_ff;
      win_w_in  = win_w_ff;
      win_h_in  = win_h_ff;
      if (req_ff.mode == MODE_CHECK) begin
         cur_x_in = chk_new ? nb_x_ff : seed_x_ff;
         cur_y_in = chk_new ? nb_y_ff : seed_y_ff;
      end
      if (req_ff.mode == MODE_CLOSE) begin
         win_x_in  = box_xmin_ff;
         win_y_in  = box_ymin_ff;
         win_xe_in = box_xmax_ff;
         win_ye_in = box_ymax_ff;
         win_w_in  = (CXW+1)'(box_xmax_ff) - (CXW+1)'(box_xmin_ff) + (CXW+1)'(1);
         win_h_in  = (CYW+1)'(box_ymax_ff) - (CYW+1)'(box_ymin_ff) + (CYW+1)'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         tgt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_x_ff    <= '0;
         seed_y_ff    <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         box_xmin_ff  <= '0;
         box_xmax_ff  <= '0;
         box_ymin_ff  <= '0;
         box_ymax_ff  <= '0;
         win_x_ff     <= '0;
         win_y_ff     <= '0;
         win_xe_ff    <= '0;
         win_ye_ff    <= '0;
         win_w_ff     <= '0;
         win_h_ff     <= '0;
      end else begin
         if (cmd.sweep) begin
            idx_ff <= idx_ff + AW'(1);
         end else if (cmd.calc) begin
            if (req_ff.mode == MODE_ACCEPT || req_ff.mode == MODE_REJECT) begin
               idx_ff <= tgt_idx_ff;
            end else begin
               idx_ff <= idx_calc;
            end
         end else if (cmd.walk) begin
            idx_ff <= row_end ? row_jump : idx_ff + AW'(1);
         end

         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cmd.commit) begin
            cur_x_ff  <= cur_x_in;
            cur_y_ff  <= cur_y_in;
            win_x_ff  <= win_x_in;
            win_y_ff  <= win_y_in;
            win_xe_ff <= win_xe_in;
            win_ye_ff <= win_ye_in;
            win_w_ff  <= win_w_in;
            win_h_ff  <= win_h_in;
            if (req_ff.mode == MODE_SEED) begin
               seed_x_ff <= sat_x;
               seed_y_ff <= sat_y;
            end
            if (req_ff.mode == MODE_START) begin
               box_xmin_ff <= sat_x;
               box_xmax_ff <= sat_x;
               box_ymin_ff <= sat_y;
               box_ymax_ff <= sat_y;
            end
            if (chk_new) begin
               tgt_valid_ff <= 1'b1;
               if (nb_x_ff > box_xmax_ff) box_xmax_ff <= nb_x_ff;
               if (nb_x_ff < box_xmin_ff) box_xmin_ff <= nb_x_ff;
               if (nb_y_ff > box_ymax_ff) box_ymax_ff <= nb_y_ff;
               if (nb_y_ff < box_ymin_ff) box_ymin_ff <= nb_y_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.calc) begin
         nb_x_ff  <= nb_x_calc;
         nb_y_ff  <= nb_y_calc;
         nb_in_ff <= (req_ff.mode == MODE_LOAD) ? pos_in : nb_ok;
         cx_ff    <= win_x_ff;
         cy_ff    <= win_y_ff;
      end else if (cmd.walk) begin
         if (row_end) begin
            cx_ff <= win_x_ff;
            cy_ff <= cy_ff + CYW'(1);
         end else begin
            cx_ff <= cx_ff + CXW'(1);
         end
      end
      if (cmd.commit) begin
         if (chk_new) begin
            tgt_idx_ff <= idx_ff;
         end
         rsp_ff.status <= status_calc;
         rsp_ff.nb_x   <= X_W'(cur_x_in);
         rsp_ff.nb_y   <= Y_W'(cur_y_in);
         rsp_ff.win_x  <= X_W'(win_x_in);
         rsp_ff.win_y  <= Y_W'(win_y_in);
         rsp_ff.win_w  <= X_W'(win_w_in);
         rsp_ff.win_h  <= Y_W'(win_h_in);
      end
   end

   // mask write ports: all zeroed on sweep, explored and region zeroed on window walk, marks on commit
   assign expl_we = cmd.sweep || cmd.walk || (cmd.commit && chk_new);
   assign expl_wd = cmd.commit;

   assign forb_we = cmd.sweep || (cmd.commit &&
                    ((req_ff.mode == MODE_LOAD && nb_in_ff) ||
                     (req_ff.mode == MODE_ACCEPT && tgt_valid_ff)));
   assign forb_wd = cmd.commit && ((req_ff.mode == MODE_ACCEPT) || req_ff.forbid_bit);

   assign reg_we = cmd.sweep || cmd.walk || (cmd.commit && tgt_valid_ff &&
                   (req_ff.mode == MODE_ACCEPT || req_ff.mode == MODE_REJECT));
   assign reg_wd = !cmd.commit ? REGION_NONE :
                   (req_ff.mode == MODE_ACCEPT) ? REGION_BODY : REGION_BORDER;

   always_ff @(posedge clock) begin
      if (expl_we) begin
         expl_mem[idx_ff] <= expl_wd;
      end
      if (cmd.read) begin
         expl_rd_ff <= expl_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (forb_we) begin
         forb_mem[idx_ff] <= forb_wd;
      end
      if (cmd.read) begin
         forb_rd_ff <= forb_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reg_we) begin
         reg_mem[idx_ff] <= reg_wd;
      end
   end

   assign sts.mode       = req_ff.mode;
   assign sts.win_empty  = (win_w_ff == '0) || (win_h_ff == '0);
   assign sts.walk_last  = walk_last;
   assign sts.sweep_last = idx_ff == A_LAST;
   assign sts.slot_free  = slot_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RGMT_ASSERT_NEXT(a_commit_rsp, cmd.commit, rsp_valid_ff, "commit did not present a result")
   `RGMT_ASSERT_SAME(a_walk_window, cmd.walk, !sts.win_empty, "window walk on empty window")
   `RGMT_ASSERT_SAME(a_walk_bounds, cmd.walk, cx_ff >= win_x_ff && cx_ff <= win_xe_ff && cy_ff >= win_y_ff && cy_ff <= win_ye_ff, "window walk left the window")

endmodule

// ----- hdl/region_grow_mask_tracker_top.sv -----
// Sequence: after its transfer a check passes the calc, read and done states, other modes
// calc and done; a window clear also walks each pixel of the window (win_w * win_h).
// One item at a time (index, mask read, commit): no new item is taken until the previous one commits.
// Reset: synchronous; a clearing pass then zeroes all masks over all IMG_WIDTH * IMG_HEIGHT
// pixels (307200 at 640x480), and no item is taken until it ends.
module region_grow_mask_tracker_top
   import rgmt_pkg::*;
#(
   parameter int IMG_WIDTH  = 640,
   parameter int IMG_HEIGHT = 480
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Controller sequences each item: capture, index calculation, optional
   // mask read or window walk, then commit into the output register.
   cmd_type cmd;
   sts_type sts;

   rgmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Datapath holds the masks, seed, neighbor, box, window and the output
   // register; a held result does not block the next transfer in.
   rgmt_dp #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
